/* rtl/risc16_subset_execute_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the execute unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RISC16_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define RISC16_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define RSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg
// Types, codes and opcode encodings of the integer execute unit.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam logic [31:0] RESET_PC_DEFAULT = 32'hA000_0000;
  localparam logic [31:0] PC_ALIGN_MASK    = 32'hFFFF_FFFC;
  localparam logic [31:0] HI_HALF_MASK     = 32'hFFFF_0000;
  localparam logic [31:0] BYTE1_MASK       = 32'h0000_FF00;
  localparam logic [31:0] LO_HALF_MASK     = 32'h0000_FFFF;
  localparam logic [15:0] NOP_WORD         = 16'h0009;

  // memory request kind
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  // access size
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  // result status
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_LOAD_WAIT = 2'd1;
  localparam logic [1:0] ST_HALT      = 2'd2;
  localparam logic [1:0] ST_REJECT    = 2'd3;

  // item action
  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // major opcode, bits 15:12
  localparam logic [3:0] OP_SYS     = 4'h0;
  localparam logic [3:0] OP_MOVL_S4 = 4'h1;
  localparam logic [3:0] OP_STORE   = 4'h2;
  localparam logic [3:0] OP_CMP     = 4'h3;
  localparam logic [3:0] OP_SHIFT   = 4'h4;
  localparam logic [3:0] OP_MOVL_L4 = 4'h5;
  localparam logic [3:0] OP_LOAD    = 4'h6;
  localparam logic [3:0] OP_ADDI    = 4'h7;
  localparam logic [3:0] OP_DISP    = 4'h8;
  localparam logic [3:0] OP_IMM     = 4'hC;
  localparam logic [3:0] OP_MOVL_PC = 4'hD;
  localparam logic [3:0] OP_MOVI    = 4'hE;

  // group 0, low nibble / m field
  localparam logic [3:0] SYS_PREF_D = 4'h3;
  localparam logic [3:0] SYS_PREF_M = 4'h8;
  localparam logic [3:0] SYS_STS_D  = 4'hA;
  localparam logic [3:0] SYS_STS_M  = 4'h1;

  // group 2, low nibble
  localparam logic [3:0] ST2_MOVB   = 4'h0;
  localparam logic [3:0] ST2_MOVW   = 4'h1;
  localparam logic [3:0] ST2_MOVL   = 4'h2;
  localparam logic [3:0] ST2_MOVW_D = 4'h5;
  localparam logic [3:0] ST2_TST    = 4'h8;
  localparam logic [3:0] ST2_XOR    = 4'hA;
  localparam logic [3:0] ST2_MULU   = 4'hE;

  // group 3, low nibble
  localparam logic [3:0] CMP_HI = 4'h6;

  // group 4, low byte
  localparam logic [7:0] SH_SHLR   = 8'h01;
  localparam logic [7:0] SH_ROTR   = 8'h05;
  localparam logic [7:0] SH_SHLR2  = 8'h09;
  localparam logic [7:0] SH_DT     = 8'h10;
  localparam logic [7:0] SH_SHLL8  = 8'h18;
  localparam logic [7:0] SH_SHAR   = 8'h21;
  localparam logic [7:0] SH_SHLL16 = 8'h28;
  localparam logic [7:0] SH_JMP    = 8'h2B;

  // group 6, low nibble
  localparam logic [3:0] LD_MOVL   = 4'h2;
  localparam logic [3:0] LD_MOV    = 4'h3;
  localparam logic [3:0] LD_MOVW_P = 4'h5;
  localparam logic [3:0] LD_MOVL_P = 4'h6;
  localparam logic [3:0] LD_SWAPB  = 4'h8;
  localparam logic [3:0] LD_SWAPW  = 4'h9;

  // group 8, n field
  localparam logic [3:0] D8_MOVW_S = 4'h1;
  localparam logic [3:0] D8_MOVW_L = 4'h5;
  localparam logic [3:0] D8_BT     = 4'h9;
  localparam logic [3:0] D8_BF     = 4'hB;

  // group C, n field
  localparam logic [3:0] IC_MOVA = 4'h7;
  localparam logic [3:0] IC_TST  = 4'h8;
  localparam logic [3:0] IC_OR   = 4'hB;

  localparam logic [3:0] R0_ADDR = 4'h0;

  typedef struct packed {
    logic        t_flag;
    logic [31:0] mac_low;
    logic [31:0] prog_counter;
    logic [31:0] next_pc;
    logic        load_pending;
    logic [3:0]  load_dest;
    logic [1:0]  load_size;
    logic        halted;
  } arch_state_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } gpr_wr_t;

  typedef struct packed {
    logic [1:0]  mem_kind;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [31:0] fetch_pc;
    logic [1:0]  status;
  } exec_result_t;

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

/* rtl/rse_if.sv */
// ----------------------------------------------------------------------------
// Execute unit channels
// Valid/ready channels for instructions, results and the reset_pc write.
// ----------------------------------------------------------------------------
interface rse_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] opcode;
  logic [31:0] load_data;

  modport source (output valid, action, opcode, load_data, input ready);
  modport sink   (input valid, action, opcode, load_data, output ready);
endinterface

interface rse_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mem_kind;
  logic [1:0]  mem_size;
  logic [31:0] mem_address;
  logic [31:0] mem_write_data;
  logic [31:0] fetch_pc;
  logic [1:0]  status;

  modport source (output valid, mem_kind, mem_size, mem_address, mem_write_data,
                  fetch_pc, status, input ready);
  modport sink   (input valid, mem_kind, mem_size, mem_address, mem_write_data,
                  fetch_pc, status, output ready);
endinterface

interface rse_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] reset_pc;

  modport source (output valid, reset_pc, input ready);
  modport sink   (input valid, reset_pc, output ready);
endinterface

/* rtl/rse_regfile.sv */
// ----------------------------------------------------------------------------
// rse_regfile
// 16 x 32 general register file: registered reads of Rn/Rm with write bypass,
// R0 kept in its own flop for the fixed-R0 operations.
// ----------------------------------------------------------------------------
module rse_regfile
  import rse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr_n,
  input  logic [3:0]  rd_addr_m,
  input  gpr_wr_t     wr,
  output logic [31:0] rn,
  output logic [31:0] rm,
  output logic [31:0] r0
);

  logic [31:0] mem [16];
  logic [15:0] written;
  logic [31:0] rn_mem;
  logic [31:0] rm_mem;
  logic        rn_vld;
  logic        rm_vld;
  logic        rn_byp;
  logic        rm_byp;
  logic [31:0] byp_data;
  logic [31:0] r0_reg;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rn_mem <= mem[rd_addr_n];
      rm_mem <= mem[rd_addr_m];
    end
  end

  // valid bits give the all-zero reset view; bypass covers a write landing
  // on the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      r0_reg  <= '0;
      rn_vld  <= 1'b0;
      rm_vld  <= 1'b0;
      rn_byp  <= 1'b0;
      rm_byp  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
        if (wr.addr == R0_ADDR) begin
          r0_reg <= wr.data;
        end
      end
      if (rd_en) begin
        rn_vld <= written[rd_addr_n];
        rm_vld <= written[rd_addr_m];
        rn_byp <= wr.en && (wr.addr == rd_addr_n);
        rm_byp <= wr.en && (wr.addr == rd_addr_m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr.data;
    end
  end

  assign rn = rn_byp ? byp_data : (rn_vld ? rn_mem : '0);
  assign rm = rm_byp ? byp_data : (rm_vld ? rm_mem : '0);
  assign r0 = r0_reg;

endmodule

/* rtl/rse_exec.sv */
// ----------------------------------------------------------------------------
// rse_exec
// Decode and execute of one item: next architectural state, register write
// and the result fields.
// ----------------------------------------------------------------------------
module rse_exec
  import rse_pkg::*;
(
  input  arch_state_t  st,
  input  logic         action,
  input  logic [15:0]  opcode,
  input  logic [31:0]  load_data,
  input  logic [31:0]  rn,
  input  logic [31:0]  rm,
  input  logic [31:0]  r0,
  output arch_state_t  st_next,
  output gpr_wr_t      gpr_wr,
  output exec_result_t res
);

  logic [3:0]  n;
  logic [3:0]  m;
  logic [3:0]  d;
  logic [7:0]  imm;
  logic [31:0] simm;
  logic [31:0] pc_rel;
  logic [31:0] br_target;
  logic [31:0] rn_dec;

  assign n         = opcode[11:8];
  assign m         = opcode[7:4];
  assign d         = opcode[3:0];
  assign imm       = opcode[7:0];
  assign simm      = sext8(imm);
  assign pc_rel    = (st.prog_counter & PC_ALIGN_MASK) + {22'd0, imm, 2'b00} + 32'd4;
  assign br_target = st.prog_counter + {simm[30:0], 1'b0} + 32'd4;
  assign rn_dec    = rn - 32'd1;

  always_comb begin
    logic        bad;
    logic        jumped;
    logic        rd;
    logic [31:0] ld_val;

    bad     = 1'b0;
    jumped  = 1'b0;
    rd      = 1'b0;
    ld_val  = load_data;
    st_next = st;
    gpr_wr  = '0;
    res     = '0;
    res.status = ST_DONE;

    if (st.halted) begin
      res.status = ST_HALT;
    end else if (action == ACT_LOAD) begin
      if (!st.load_pending) begin
        res.status = ST_REJECT;
      end else begin
        case (st.load_size)
          SIZE_BYTE: ld_val = sext8(load_data[7:0]);
          SIZE_WORD: ld_val = sext16(load_data[15:0]);
          default:   ld_val = load_data;
        endcase
        gpr_wr = '{en: 1'b1, addr: st.load_dest, data: ld_val};
        st_next.load_pending = 1'b0;
      end
    end else if (st.load_pending) begin
      res.status = ST_REJECT;
    end else begin
      case (opcode[15:12])
        OP_SYS: begin
          if (d == SYS_PREF_D && m == SYS_PREF_M) begin
          end else if (opcode == NOP_WORD) begin
          end else if (d == SYS_STS_D && m == SYS_STS_M) begin
            gpr_wr = '{en: 1'b1, addr: n, data: st.mac_low};
          end else begin
            bad = 1'b1;
          end
        end
        OP_MOVL_S4: begin
          res.mem_kind       = MEM_WRITE;
          res.mem_size       = SIZE_LONG;
          res.mem_address    = rn + {26'd0, d, 2'b00};
          res.mem_write_data = rm;
        end
        OP_STORE: begin
          case (d)
            ST2_MOVB: begin
              res.mem_kind       = MEM_WRITE;
              res.mem_size       = SIZE_BYTE;
              res.mem_address    = rn;
              res.mem_write_data = {24'd0, rm[7:0]};
            end
            ST2_MOVW: begin
              res.mem_kind       = MEM_WRITE;
              res.mem_size       = SIZE_WORD;
              res.mem_address    = rn;
              res.mem_write_data = rm & LO_HALF_MASK;
            end
            ST2_MOVL: begin
              res.mem_kind       = MEM_WRITE;
              res.mem_size       = SIZE_LONG;
              res.mem_address    = rn;
              res.mem_write_data = rm;
            end
            ST2_MOVW_D: begin
              res.mem_kind       = MEM_WRITE;
              res.mem_size       = SIZE_WORD;
              res.mem_address    = rn - 32'd2;
              res.mem_write_data = rm & LO_HALF_MASK;
              gpr_wr = '{en: 1'b1, addr: n, data: rn - 32'd2};
            end
            ST2_TST:  st_next.t_flag = ((rm & rn) == '0);
            ST2_XOR:  gpr_wr = '{en: 1'b1, addr: n, data: rm ^ rn};
            ST2_MULU: st_next.mac_low = rm[15:0] * rn[15:0];
            default:  bad = 1'b1;
          endcase
        end
        OP_CMP: begin
          if (d == CMP_HI) begin
            st_next.t_flag = (rn > rm);
          end else begin
            bad = 1'b1;
          end
        end
        OP_SHIFT: begin
          case (imm)
            SH_SHLR: begin
              st_next.t_flag = rn[0];
              gpr_wr = '{en: 1'b1, addr: n, data: {1'b0, rn[31:1]}};
            end
            SH_ROTR: begin
              st_next.t_flag = rn[0];
              gpr_wr = '{en: 1'b1, addr: n, data: {rn[0], rn[31:1]}};
            end
            SH_SHLR2: gpr_wr = '{en: 1'b1, addr: n, data: {2'b00, rn[31:2]}};
            SH_DT: begin
              gpr_wr = '{en: 1'b1, addr: n, data: rn_dec};
              st_next.t_flag = (rn_dec == '0);
            end
            SH_SHLL8: gpr_wr = '{en: 1'b1, addr: n, data: {rn[23:0], 8'd0}};
            SH_SHAR: begin
              st_next.t_flag = rn[0];
              gpr_wr = '{en: 1'b1, addr: n, data: {rn[31], rn[31:1]}};
            end
            SH_SHLL16: gpr_wr = '{en: 1'b1, addr: n, data: {rn[15:0], 16'd0}};
            SH_JMP: begin
              // delay slot runs next, then the target
              st_next.prog_counter = st.next_pc;
              st_next.next_pc      = rn;
              jumped = 1'b1;
            end
            default: bad = 1'b1;
          endcase
        end
        OP_MOVL_L4: begin
          rd = 1'b1;
          res.mem_size      = SIZE_LONG;
          res.mem_address   = rm + {26'd0, d, 2'b00};
          st_next.load_dest = n;
        end
        OP_LOAD: begin
          case (d)
            LD_MOVL: begin
              rd = 1'b1;
              res.mem_size      = SIZE_LONG;
              res.mem_address   = rm;
              st_next.load_dest = n;
            end
            LD_MOV: gpr_wr = '{en: 1'b1, addr: n, data: rm};
            LD_MOVW_P: begin
              rd = 1'b1;
              res.mem_size      = SIZE_WORD;
              res.mem_address   = rm;
              st_next.load_dest = n;
              gpr_wr = '{en: 1'b1, addr: m, data: rm + 32'd2};
            end
            LD_MOVL_P: begin
              rd = 1'b1;
              res.mem_size      = SIZE_LONG;
              res.mem_address   = rm;
              st_next.load_dest = n;
              gpr_wr = '{en: 1'b1, addr: m, data: rm + 32'd4};
            end
            LD_SWAPB: gpr_wr = '{en: 1'b1, addr: n,
                                 data: (rm & HI_HALF_MASK) | {16'd0, rm[7:0], rm[15:8]}};
            LD_SWAPW: gpr_wr = '{en: 1'b1, addr: n, data: {rm[15:0], rm[31:16]}};
            default:  bad = 1'b1;
          endcase
        end
        OP_ADDI: gpr_wr = '{en: 1'b1, addr: n, data: rn + simm};
        OP_DISP: begin
          case (n)
            D8_MOVW_S: begin
              res.mem_kind       = MEM_WRITE;
              res.mem_size       = SIZE_WORD;
              res.mem_address    = rm + {27'd0, d, 1'b0};
              res.mem_write_data = r0 & LO_HALF_MASK;
            end
            D8_MOVW_L: begin
              rd = 1'b1;
              res.mem_size      = SIZE_WORD;
              res.mem_address   = rm + {27'd0, d, 1'b0};
              st_next.load_dest = R0_ADDR;
            end
            D8_BT, D8_BF: begin
              if ((n == D8_BT) == st.t_flag) begin
                st_next.prog_counter = br_target;
                st_next.next_pc      = br_target + 32'd2;
                jumped = 1'b1;
              end
            end
            default: bad = 1'b1;
          endcase
        end
        OP_IMM: begin
          case (n)
            IC_MOVA: gpr_wr = '{en: 1'b1, addr: R0_ADDR, data: pc_rel};
            IC_TST:  st_next.t_flag = ((r0[7:0] & imm) == '0);
            IC_OR:   gpr_wr = '{en: 1'b1, addr: R0_ADDR, data: r0 | {24'd0, imm}};
            default: bad = 1'b1;
          endcase
        end
        OP_MOVL_PC: begin
          rd = 1'b1;
          res.mem_size      = SIZE_LONG;
          res.mem_address   = pc_rel;
          st_next.load_dest = n;
        end
        OP_MOVI: gpr_wr = '{en: 1'b1, addr: n, data: simm};
        default: bad = 1'b1;
      endcase

      if (bad) begin
        st_next        = st;
        st_next.halted = 1'b1;
        gpr_wr         = '0;
        res            = '0;
        res.status     = ST_HALT;
      end else begin
        if (rd) begin
          res.mem_kind         = MEM_READ;
          st_next.load_pending = 1'b1;
          st_next.load_size    = res.mem_size;
          res.status           = ST_LOAD_WAIT;
        end
        if (!jumped) begin
          st_next.prog_counter = st.next_pc;
          st_next.next_pc      = st.next_pc + 32'd2;
        end
      end
    end

    res.fetch_pc = st_next.prog_counter;
  end

endmodule

/* rtl/risc16_subset_execute_unit.sv */
// ----------------------------------------------------------------------------
// risc16_subset_execute_unit
// Executes one 16-bit instruction of the integer subset per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   instr  : action/opcode/load_data in. action 0 executes the opcode fetched
//            at the last fetch_pc; action 1 returns data for a pending load.
//   result : one transfer per instruction: memory request, next fetch_pc and
//            status (done, awaiting load, halted, rejected).
//   cfg    : reset_pc write; reloads the program counter (reset uses 0xA0000000). Write only
//            while no instruction is in flight.
// Result valid rises once the instr item has passed the input register and
// been executed into the result register. One instruction per cycle is
// sustained while result is not stalled; the register file read is
// registered at the input and a write from the instruction ahead is bypassed,
// so dependent instructions issue back to back.
// When result is stalled, the held result keeps one more instruction parked
// in the input register; instr.ready drops only when both are full.
// Reset (synchronous, rst high) clears all registers to zero, T, MACL, the
// load state and the halt flag, and sets the PC to 0xA0000000.
// ----------------------------------------------------------------------------
`include "risc16_subset_execute_unit_assert.svh"

module risc16_subset_execute_unit
  import rse_pkg::*;
(
  input logic          clk,
  input logic          rst,
  rse_in_if.sink       instr,
  rse_out_if.source    result,
  rse_cfg_if.sink      cfg
);

  logic         in_vld;
  logic         in_action;
  logic [15:0]  in_opcode;
  logic [31:0]  in_load_data;
  logic         out_vld;
  exec_result_t out_res;
  logic         instr_xfer;
  logic         exec_fire;
  arch_state_t  st;
  arch_state_t  st_next;
  gpr_wr_t      gpr_wr;
  gpr_wr_t      gpr_wr_q;
  exec_result_t res;
  logic [31:0]  rn;
  logic [31:0]  rm;
  logic [31:0]  r0;

  assign exec_fire   = in_vld && (!out_vld || result.ready);
  assign instr.ready = !in_vld || exec_fire;
  assign instr_xfer  = instr.valid && instr.ready;
  // the executing item owns the PC on that edge
  assign cfg.ready   = !exec_fire;

  // only the executing item writes the register file
  assign gpr_wr_q = exec_fire ? gpr_wr : '0;

  rse_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (instr_xfer),
    .rd_addr_n (instr.opcode[11:8]),
    .rd_addr_m (instr.opcode[7:4]),
    .wr        (gpr_wr_q),
    .rn        (rn),
    .rm        (rm),
    .r0        (r0)
  );

  rse_exec u_exec (
    .st        (st),
    .action    (in_action),
    .opcode    (in_opcode),
    .load_data (in_load_data),
    .rn        (rn),
    .rm        (rm),
    .r0        (r0),
    .st_next   (st_next),
    .gpr_wr    (gpr_wr),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (instr.ready) begin
      in_vld <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr_xfer) begin
      in_action    <= instr.action;
      in_opcode    <= instr.opcode;
      in_load_data <= instr.load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.t_flag       <= 1'b0;
      st.mac_low      <= '0;
      st.prog_counter <= RESET_PC_DEFAULT;
      st.next_pc      <= RESET_PC_DEFAULT + 32'd2;
      st.load_pending <= 1'b0;
      st.load_dest    <= '0;
      st.load_size    <= SIZE_BYTE;
      st.halted       <= 1'b0;
    end else if (exec_fire) begin
      st <= st_next;
    end else if (cfg.valid) begin
      st.prog_counter <= cfg.reset_pc;
      st.next_pc      <= cfg.reset_pc + 32'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (exec_fire) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_res <= res;
    end
  end

  assign result.valid          = out_vld;
  assign result.mem_kind       = out_res.mem_kind;
  assign result.mem_size       = out_res.mem_size;
  assign result.mem_address    = out_res.mem_address;
  assign result.mem_write_data = out_res.mem_write_data;
  assign result.fetch_pc       = out_res.fetch_pc;
  assign result.status         = out_res.status;

  `RSE_ASSERT_NEXT(a_halt_sticky, st.halted, st.halted, "halt flag cleared without reset")
  `RSE_ASSERT_NOW(a_no_write_halted, exec_fire && st.halted, !gpr_wr_q.en, "register write while halted")
  `RSE_ASSERT_NEXT(a_load_wait_pending, exec_fire && res.status == ST_LOAD_WAIT, st.load_pending, "load issued without pending state")
  `RSE_ASSERT_NOW(a_ready_when_drained, !out_vld, instr.ready, "instr not ready with empty result stage")

endmodule
